FILE: hdl/assert_macros.svh
// Assertion macros shared by the sequencer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RBS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/rbs_pkg.sv
// Shared types, constants and the control store of the remote button sequencer.
// No dependencies; imported by rbs_press_queue and remote_button_sequencer.
`default_nettype none

package rbs_pkg;

  localparam int TEMP_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int DEG_W      = 6;
  localparam int DIST_W     = 10;
  localparam int CNT_W      = 5;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_MAX = 2'd1;

  localparam logic [1:0] MODE_COOL = 2'd0;
  localparam logic [1:0] MODE_DRY  = 2'd1;
  localparam logic [1:0] MODE_FAN  = 2'd2;

  localparam logic [TEMP_W-1:0] TEMP_MIN_RST = 9'd150;
  localparam logic [TEMP_W-1:0] TEMP_MAX_RST = 9'd300;
  localparam logic [DEG_W-1:0]  TEMP_DEG_RST = 6'd25;

  localparam logic [CNT_W-1:0]  MAX_RUN    = 5'd19;
  localparam logic [CNT_W-1:0]  TEMP_LIMIT = 5'd18;
  localparam logic [DIST_W-1:0] TEMP_STEP  = 10'd10;
  localparam logic [DIST_W-1:0] TEMP_ROUND = 10'd5;

  typedef enum logic [2:0] {
    BTN_POWER = 3'd0,
    BTN_MODE  = 3'd1,
    BTN_UP    = 3'd2,
    BTN_DOWN  = 3'd3,
    BTN_SPEED = 3'd4
  } btn_t;

  typedef struct packed {
    logic              target_power_on;
    logic [1:0]        wanted_mode;
    logic [TEMP_W-1:0] target_temp_tenths;
    logic              target_fan_high;
  } in_item_t;

  typedef struct packed {
    logic [2:0] button_code;
    logic       last_press;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic flush;
    btn_t code;
  } press_ctl_t;

  typedef enum logic [2:0] {
    U_IDLE   = 3'd0,
    U_POWER  = 3'd1,
    U_OFFCHK = 3'd2,
    U_MODE   = 3'd3,
    U_TEMP   = 3'd4,
    U_FAN    = 3'd5,
    U_FINISH = 3'd6
  } upc_t;

  typedef enum logic [2:0] {
    C_ALWAYS    = 3'd0,
    C_IN        = 3'd1,
    C_PWR_DIFF  = 3'd2,
    C_OFF       = 3'd3,
    C_MODE_LEFT = 3'd4,
    C_TEMP_GO   = 3'd5,
    C_FAN_DIFF  = 3'd6
  } cond_t;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_POWER  = 3'd2,
    OP_MODE   = 3'd3,
    OP_TEMP   = 3'd4,
    OP_FAN    = 3'd5,
    OP_FINISH = 3'd6
  } op_t;

  typedef struct packed {
    cond_t cond;
    op_t   op;
    logic  emit;
    btn_t  btn;
    upc_t  on_true;
    upc_t  on_false;
  } uword_t;

  function automatic uword_t rbs_ucode(input upc_t addr);
    uword_t w;
    case (addr)
      U_IDLE:   w = '{C_IN,        OP_LOAD,   1'b0, BTN_POWER, U_POWER,  U_IDLE};
      U_POWER:  w = '{C_PWR_DIFF,  OP_POWER,  1'b1, BTN_POWER, U_OFFCHK, U_OFFCHK};
      U_OFFCHK: w = '{C_OFF,       OP_NONE,   1'b0, BTN_POWER, U_FINISH, U_MODE};
      U_MODE:   w = '{C_MODE_LEFT, OP_MODE,   1'b1, BTN_MODE,  U_MODE,   U_TEMP};
      U_TEMP:   w = '{C_TEMP_GO,   OP_TEMP,   1'b1, BTN_UP,    U_TEMP,   U_FAN};
      U_FAN:    w = '{C_FAN_DIFF,  OP_FAN,    1'b1, BTN_SPEED, U_FINISH, U_FINISH};
      U_FINISH: w = '{C_ALWAYS,    OP_FINISH, 1'b0, BTN_POWER, U_IDLE,   U_IDLE};
      default:  w = '{C_ALWAYS,    OP_NONE,   1'b0, BTN_POWER, U_IDLE,   U_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/remote_button_sequencer.sv
// Remote button sequencer: a one-request-at-a-time unit that turns a target appliance
// state into the button presses that reach it, one result per press with the final press
// of each run marked. A seven-step control store walks one step per clock unless the
// press queue holds it: take the request, power, off check, mode (repeated while mode
// presses remain), temperature (repeated while temperature presses remain), fan, finish;
// a run that ends at power off goes from the off check straight to finish. The power and
// speed presses ride on their own steps. The next request is taken once the finish step
// has handed off the last press. Configuration writes are always ready. Depends on
// rbs_pkg, rbs_press_queue and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module remote_button_sequencer #(
  parameter int MODE_COUNT = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire rbs_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output rbs_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rbs_pkg::TEMP_W-1:0]    cfg_data
);
  import rbs_pkg::*;

  localparam int MCW = (MODE_COUNT > 1) ? $clog2(MODE_COUNT) : 1;
  localparam int SW  = MCW + 2;

  upc_t       upc_r, upc_nxt;
  uword_t     uw;
  logic       cond_true;
  logic       advance;
  logic       hold;
  logic       pend_valid;
  press_ctl_t ctl;

  logic [TEMP_W-1:0] temp_min_r, temp_max_r;
  logic              power_on_r, power_on_nxt;
  logic [1:0]        cur_mode_r, cur_mode_nxt;
  logic [DEG_W-1:0]  cur_temp_r, cur_temp_nxt;
  logic              fan_high_r, fan_high_nxt;

  logic              tgt_power_r, tgt_power_nxt;
  logic              tgt_fan_r, tgt_fan_nxt;
  logic [TEMP_W-1:0] tgt_temp_r, tgt_temp_nxt;
  logic [1:0]        mode_tgt_r, mode_tgt_nxt;
  logic [MCW-1:0]    mode_cnt_r, mode_cnt_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic              down_r, down_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;

  logic [TEMP_W-1:0] tt_lo, tt_clamp;
  logic [SW-1:0]     tm_e, cur_e, mc_e, mode_diff;
  logic              mode_ok;
  logic [DIST_W-1:0] tt_e, cur10, dist_up, dist_dn;

  assign uw = rbs_ucode(upc_r);

  always_comb begin
    case (uw.cond)
      C_ALWAYS:    cond_true = 1'b1;
      C_IN:        cond_true = in_valid;
      C_PWR_DIFF:  cond_true = power_on_r != tgt_power_r;
      C_OFF:       cond_true = !power_on_r;
      C_MODE_LEFT: cond_true = mode_cnt_r != '0;
      C_TEMP_GO:   cond_true = (cur_mode_r == MODE_COOL) && (dist_r >= TEMP_STEP)
                               && (n_r < TEMP_LIMIT);
      C_FAN_DIFF:  cond_true = fan_high_r != tgt_fan_r;
      default:     cond_true = 1'b0;
    endcase
  end

  assign advance = !hold;

  always_comb begin
    upc_nxt = upc_r;
    if (advance) begin
      upc_nxt = cond_true ? uw.on_true : uw.on_false;
    end
  end

  always_comb begin
    in_stall   = upc_r != U_IDLE;
    ctl.push   = uw.emit && cond_true;
    ctl.flush  = uw.op == OP_FINISH;
    ctl.code   = (uw.op == OP_TEMP && down_r) ? BTN_DOWN : uw.btn;
  end

  assign cfg_ready = 1'b1;

  assign tt_lo    = (in_data.target_temp_tenths < temp_min_r) ? temp_min_r
                                                              : in_data.target_temp_tenths;
  assign tt_clamp = (tt_lo > temp_max_r) ? temp_max_r : tt_lo;

  assign tm_e      = SW'(in_data.wanted_mode);
  assign cur_e     = SW'(cur_mode_r);
  assign mc_e      = SW'(MODE_COUNT);
  assign mode_ok   = tm_e < mc_e;
  assign mode_diff = (tm_e >= cur_e) ? (tm_e - cur_e) : (tm_e + mc_e - cur_e);

  assign tt_e    = {1'b0, tgt_temp_r};
  assign cur10   = {1'b0, cur_temp_r, 3'b000} + {3'b000, cur_temp_r, 1'b0};
  assign dist_up = tt_e - cur10 + TEMP_ROUND;
  assign dist_dn = cur10 - tt_e + TEMP_ROUND;

  always_comb begin
    power_on_nxt  = power_on_r;
    cur_mode_nxt  = cur_mode_r;
    cur_temp_nxt  = cur_temp_r;
    fan_high_nxt  = fan_high_r;
    tgt_power_nxt = tgt_power_r;
    tgt_fan_nxt   = tgt_fan_r;
    tgt_temp_nxt  = tgt_temp_r;
    mode_tgt_nxt  = mode_tgt_r;
    mode_cnt_nxt  = mode_cnt_r;
    dist_nxt      = dist_r;
    down_nxt      = down_r;
    n_nxt         = n_r;
    if (advance) begin
      if (ctl.push) begin
        n_nxt = n_r + 5'd1;
      end
      case (uw.op)
        OP_LOAD: begin
          if (cond_true) begin
            tgt_power_nxt = in_data.target_power_on;
            tgt_fan_nxt   = in_data.target_fan_high;
            tgt_temp_nxt  = tt_clamp;
            mode_tgt_nxt  = mode_ok ? in_data.wanted_mode : cur_mode_r;
            mode_cnt_nxt  = (mode_ok && in_data.wanted_mode != cur_mode_r)
                            ? mode_diff[MCW-1:0] : '0;
            n_nxt         = '0;
          end
        end
        OP_POWER: begin
          if (cond_true) begin
            power_on_nxt = tgt_power_r;
          end
          down_nxt = (tt_e + 10'd1) < cur10;
          dist_nxt = (tt_e >= cur10) ? dist_up : dist_dn;
        end
        OP_MODE: begin
          if (cond_true) begin
            mode_cnt_nxt = mode_cnt_r - MCW'(1);
          end else begin
            cur_mode_nxt = mode_tgt_r;
          end
        end
        OP_TEMP: begin
          if (cond_true) begin
            dist_nxt     = dist_r - TEMP_STEP;
            cur_temp_nxt = down_r ? cur_temp_r - 6'd1 : cur_temp_r + 6'd1;
          end
        end
        OP_FAN: begin
          if (cond_true) begin
            fan_high_nxt = tgt_fan_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r      <= U_IDLE;
      temp_min_r <= TEMP_MIN_RST;
      temp_max_r <= TEMP_MAX_RST;
      power_on_r <= 1'b1;
      cur_mode_r <= MODE_COOL;
      cur_temp_r <= TEMP_DEG_RST;
      fan_high_r <= 1'b0;
      n_r        <= '0;
    end else begin
      upc_r      <= upc_nxt;
      power_on_r <= power_on_nxt;
      cur_mode_r <= cur_mode_nxt;
      cur_temp_r <= cur_temp_nxt;
      fan_high_r <= fan_high_nxt;
      n_r        <= n_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TEMP_MIN) begin
          temp_min_r <= cfg_data;
        end else if (cfg_index == REG_TEMP_MAX) begin
          temp_max_r <= cfg_data;
        end
      end
    end
    tgt_power_r <= tgt_power_nxt;
    tgt_fan_r   <= tgt_fan_nxt;
    tgt_temp_r  <= tgt_temp_nxt;
    mode_tgt_r  <= mode_tgt_nxt;
    mode_cnt_r  <= mode_cnt_nxt;
    dist_r      <= dist_nxt;
    down_r      <= down_nxt;
  end

  rbs_press_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .hold       (hold),
    .pend_valid (pend_valid),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  `RBS_ASSERT(a_idle_empty, clk, rst_n, (upc_r != U_IDLE) || !pend_valid, "press left pending at idle")
  `RBS_ASSERT(a_mode_range, clk, rst_n, SW'(cur_mode_r) < SW'(MODE_COUNT), "mode out of range")
  `RBS_ASSERT(a_run_length, clk, rst_n, n_r <= MAX_RUN, "press run too long")

endmodule

`default_nettype wire

FILE: hdl/rbs_press_queue.sv
// Press holding slot and registered result port of the button sequencer.
// Depends on rbs_pkg and assert_macros.svh; marks the final press of each run.
`default_nettype none
`include "assert_macros.svh"

module rbs_press_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rbs_pkg::press_ctl_t ctl,
  output logic                    hold,
  output logic                    pend_valid,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rbs_pkg::out_item_t      out_data
);
  import rbs_pkg::*;

  logic      pend_valid_r, pend_valid_nxt;
  btn_t      pend_code_r, pend_code_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;
  logic      out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign hold     = (ctl.push || ctl.flush) && pend_valid_r && !out_free;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_code_nxt  = pend_code_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    if (!hold) begin
      if (ctl.push) begin
        if (pend_valid_r) begin
          out_valid_nxt       = 1'b1;
          out_nxt.button_code = pend_code_r;
          out_nxt.last_press  = 1'b0;
        end
        pend_valid_nxt = 1'b1;
        pend_code_nxt  = ctl.code;
      end else if (ctl.flush && pend_valid_r) begin
        out_valid_nxt       = 1'b1;
        out_nxt.button_code = pend_code_r;
        out_nxt.last_press  = 1'b1;
        pend_valid_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_code_r <= pend_code_nxt;
    out_r       <= out_nxt;
  end

  assign pend_valid = pend_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  `RBS_ASSERT_NEXT(a_flush_marks_last, clk, rst_n, ctl.flush && pend_valid_r && !hold, out_valid_r && out_r.last_press, "flushed press not marked last")
  `RBS_ASSERT(a_no_overwrite, clk, rst_n, !(ctl.push && pend_valid_r && out_valid_r && out_stall && !hold), "stalled result overwritten")

endmodule

`default_nettype wire
